// ===== rtl/frpa_pkg.sv =====
// Package for the free range page allocator: codes, widths, slot word type
// and defaults. Depends on nothing; the slot memory and top level import it.
package frpa_pkg;

   // Default sizing
   localparam int DEF_SLOTS     = 32;
   localparam int DEF_PAGE_BITS = 12;

   // Highest start address an add will take
   localparam logic [31:0] LIMIT_ADDR = 32'hFFFF_F000;

   // Command codes
   typedef enum logic [1:0] {
      OP_ADD   = 2'd0,
      OP_CUT   = 2'd1,
      OP_ALLOC = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   // Result status codes
   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_NO_SLOT = 2'd1,
      ST_NO_MEM  = 2'd2
   } status_type;

   // Sequencer states
   typedef enum logic [3:0] {
      S_IDLE,
      S_ADD_PREP1,
      S_ADD_PREP2,
      S_ADD_SCAN,
      S_ADD_DONE,
      S_CUT_CHECK,
      S_CUT_EVAL,
      S_ALLOC_CHECK,
      S_ALLOC_EVAL,
      S_FINISH
   } state_type;

   // One table slot as held in memory
   typedef struct packed {
      logic [31:0] base;
      logic [31:0] size;
   } slot_type;

endpackage

// ===== rtl/frpa_channels.sv =====
// Handshake channels of the free range page allocator: command and result.
// Plain valid/ready interfaces; no dependencies.
interface frpa_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  operation;
   logic [63:0] start_address;
   logic [63:0] length;
   logic [31:0] end_address;

   modport source (output valid, operation, start_address, length, end_address,
                   input ready);
   modport sink   (input valid, operation, start_address, length, end_address,
                   output ready);
endinterface

interface frpa_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [31:0] page_address;
   logic [5:0]  table_extent;
   logic [31:0] high_mark;
   logic [31:0] bytes_handed_out;

   modport source (output valid, status, page_address, table_extent, high_mark,
                   bytes_handed_out, input ready);
   modport sink   (input valid, status, page_address, table_extent, high_mark,
                   bytes_handed_out, output ready);
endinterface

// ===== rtl/frpa_slot_mem.sv =====
// Slot table memory: one write port, one read port with registered data.
// Depends on frpa_pkg for the slot word type.
module frpa_slot_mem #(
   parameter int SLOTS = frpa_pkg::DEF_SLOTS
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [$clog2(SLOTS)-1:0]      wr_addr,
   input  frpa_pkg::slot_type            wr_data,
   input  logic [$clog2(SLOTS)-1:0]      rd_addr,
   output frpa_pkg::slot_type            rd_data
);
   import frpa_pkg::*;

   slot_type mem [SLOTS];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, registered data
   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule

// ===== rtl/free_range_page_allocator_top.sv =====
// Free range page allocator top level: command sequencer, slot flags,
// counters and result register. Depends on frpa_pkg, frpa_channels, frpa_slot_mem.
//
//   channel | dir | words carried
//   req     | in  | operation, start_address, length, end_address
//   rsp     | out | status, page_address, table_extent, high_mark, bytes_handed_out
//
// One command at a time, stepping through the slots. Add: clip, round to pages,
// then scan the flags for an empty slot (at most SLOTS). Alloc: walk the used slots,
// take the front page of the first. Cut: walk the used slots, plus a full add for
// each leftover piece re-inserted. Then the result is loaded once its register is free.
// Reset clears the slot flags and counters at once; no clearing pass is needed.
// A new command is taken while the previous result still waits on rsp.
module free_range_page_allocator_top #(
   parameter int SLOTS     = frpa_pkg::DEF_SLOTS,
   parameter int PAGE_BITS = frpa_pkg::DEF_PAGE_BITS
) (
   input logic            clock,
   input logic            reset,
   frpa_req_if.sink       req,
   frpa_rsp_if.source     rsp
);
   import frpa_pkg::*;

   localparam int IW = $clog2(SLOTS);
   localparam int SW = $clog2(SLOTS + 1);
   localparam logic [31:0] PAGE_BYTES = 32'(64'd1 << PAGE_BITS);
   localparam logic [31:0] PAGE_MASK  = PAGE_BYTES - 32'd1;

   state_type   state_ff, state_in;
   logic [63:0] add_addr_ff, add_addr_in;
   logic [63:0] add_len_ff, add_len_in;
   logic        above_ff, above_in;
   logic [31:0] room_ff, room_in;
   logic [31:0] base_ff, base_in;
   logic [31:0] size_ff, size_in;
   logic [IW-1:0] scan_ff, scan_in;
   logic [SW-1:0] idx_ff, idx_in;
   logic [SW-1:0] siu_ff, siu_in;
   logic [31:0] hw_ff, hw_in;
   logic [31:0] total_ff, total_in;
   logic [SLOTS-1:0] nz_ff, nz_in;
   logic        ctx_cut_ff, ctx_cut_in;
   logic        pend2_ff, pend2_in;
   logic [32:0] p2_addr_ff, p2_addr_in;
   logic [32:0] p2_len_ff, p2_len_in;
   logic [31:0] cstart_ff, cstart_in;
   logic [32:0] cend_ff, cend_in;
   status_type  st_ff, st_in;
   logic [31:0] page_ff, page_in;
   logic        rsp_valid_ff, rsp_valid_in;
   status_type  rsp_status_ff, rsp_status_in;
   logic [31:0] rsp_page_ff, rsp_page_in;
   logic [5:0]  rsp_ext_ff, rsp_ext_in;
   logic [31:0] rsp_hm_ff, rsp_hm_in;
   logic [31:0] rsp_tot_ff, rsp_tot_in;

   logic          wr_en;
   logic [IW-1:0] wr_addr;
   slot_type      wr_data;
   slot_type      rd_data;

   // slot table
   frpa_slot_mem #(.SLOTS(SLOTS)) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (idx_ff[IW-1:0]),
      .rd_data (rd_data)
   );

   assign req.ready            = (state_ff == S_IDLE);
   assign rsp.valid            = rsp_valid_ff;
   assign rsp.status           = rsp_status_ff;
   assign rsp.page_address     = rsp_page_ff;
   assign rsp.table_extent     = rsp_ext_ff;
   assign rsp.high_mark        = rsp_hm_ff;
   assign rsp.bytes_handed_out = rsp_tot_ff;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         siu_ff       <= '0;
         hw_ff        <= '0;
         total_ff     <= '0;
         nz_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         siu_ff       <= siu_in;
         hw_ff        <= hw_in;
         total_ff     <= total_in;
         nz_ff        <= nz_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working and payload registers
   always_ff @(posedge clock) begin
      add_addr_ff   <= add_addr_in;
      add_len_ff    <= add_len_in;
      above_ff      <= above_in;
      room_ff       <= room_in;
      base_ff       <= base_in;
      size_ff       <= size_in;
      scan_ff       <= scan_in;
      idx_ff        <= idx_in;
      ctx_cut_ff    <= ctx_cut_in;
      pend2_ff      <= pend2_in;
      p2_addr_ff    <= p2_addr_in;
      p2_len_ff     <= p2_len_in;
      cstart_ff     <= cstart_in;
      cend_ff       <= cend_in;
      st_ff         <= st_in;
      page_ff       <= page_in;
      rsp_status_ff <= rsp_status_in;
      rsp_page_ff   <= rsp_page_in;
      rsp_ext_ff    <= rsp_ext_in;
      rsp_hm_ff     <= rsp_hm_in;
      rsp_tot_ff    <= rsp_tot_in;
   end

   // sequencer: next state and datapath
   always_comb begin
      logic [63:0] lenc;
      logic [31:0] hm;
      logic [32:0] lo, hi, s, e, cs;
      logic [31:0] newsize;

      state_in      = state_ff;
      add_addr_in   = add_addr_ff;
      add_len_in    = add_len_ff;
      above_in      = above_ff;
      room_in       = room_ff;
      base_in       = base_ff;
      size_in       = size_ff;
      scan_in       = scan_ff;
      idx_in        = idx_ff;
      siu_in        = siu_ff;
      hw_in         = hw_ff;
      total_in      = total_ff;
      nz_in         = nz_ff;
      ctx_cut_in    = ctx_cut_ff;
      pend2_in      = pend2_ff;
      p2_addr_in    = p2_addr_ff;
      p2_len_in     = p2_len_ff;
      cstart_in     = cstart_ff;
      cend_in       = cend_ff;
      st_in         = st_ff;
      page_in       = page_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp.ready;
      rsp_status_in = rsp_status_ff;
      rsp_page_in   = rsp_page_ff;
      rsp_ext_in    = rsp_ext_ff;
      rsp_hm_in     = rsp_hm_ff;
      rsp_tot_in    = rsp_tot_ff;
      wr_en         = 1'b0;
      wr_addr       = scan_ff;
      wr_data       = '{base: base_ff, size: size_ff};

      lenc    = (add_len_ff > {32'd0, room_ff}) ? {32'd0, room_ff} : add_len_ff;
      hm      = base_ff + size_ff;
      lo      = {1'b0, rd_data.base};
      hi      = lo + {1'b0, rd_data.size};
      cs      = {1'b0, cstart_ff};
      s       = (cs > lo) ? cs : lo;
      e       = (cend_ff < hi) ? cend_ff : hi;
      newsize = (rd_data.size < PAGE_BYTES) ? 32'd0 : rd_data.size - PAGE_BYTES;

      case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               st_in      = ST_OK;
               page_in    = '0;
               ctx_cut_in = 1'b0;
               idx_in     = '0;
               case (op_type'(req.operation))
                  OP_ADD: begin
                     add_addr_in = req.start_address;
                     add_len_in  = req.length;
                     state_in    = S_ADD_PREP1;
                  end
                  OP_CUT: begin
                     cstart_in  = req.start_address[31:0] & ~PAGE_MASK;
                     cend_in    = ({1'b0, req.end_address} + {1'b0, PAGE_MASK})
                                  & ~{1'b0, PAGE_MASK};
                     ctx_cut_in = 1'b1;
                     state_in   = S_CUT_CHECK;
                  end
                  OP_ALLOC: state_in = S_ALLOC_CHECK;
                  default:  state_in = S_FINISH;
               endcase
            end
         end

         // clip against the limit
         S_ADD_PREP1: begin
            above_in = add_addr_ff > {32'd0, LIMIT_ADDR};
            room_in  = LIMIT_ADDR - add_addr_ff[31:0];
            state_in = S_ADD_PREP2;
         end

         // round to pages
         S_ADD_PREP2: begin
            if (above_ff || lenc == 64'd0) begin
               state_in = S_ADD_DONE;
            end else begin
               base_in  = 32'({1'b0, add_addr_ff[31:0]} + {1'b0, PAGE_MASK}) & ~PAGE_MASK;
               size_in  = lenc[31:0] & ~PAGE_MASK;
               scan_in  = '0;
               state_in = S_ADD_SCAN;
            end
         end

         // first empty slot
         S_ADD_SCAN: begin
            if (!nz_ff[scan_ff]) begin
               wr_en          = 1'b1;
               nz_in[scan_ff] = (size_ff != 32'd0);
               if (SW'(scan_ff) >= siu_ff) begin
                  siu_in = SW'(scan_ff) + SW'(1);
               end
               if (hm > hw_ff) begin
                  hw_in = hm;
               end
               state_in = S_ADD_DONE;
            end else if (scan_ff == IW'(SLOTS - 1)) begin
               st_in    = ST_NO_SLOT;
               state_in = S_ADD_DONE;
            end else begin
               scan_in = scan_ff + IW'(1);
            end
         end

         // back to the cut (or its second leftover piece), or finish
         S_ADD_DONE: begin
            if (!ctx_cut_ff) begin
               state_in = S_FINISH;
            end else if (pend2_ff) begin
               add_addr_in = 64'(p2_addr_ff);
               add_len_in  = 64'(p2_len_ff);
               pend2_in    = 1'b0;
               state_in    = S_ADD_PREP1;
            end else begin
               idx_in   = idx_ff + SW'(1);
               state_in = S_CUT_CHECK;
            end
         end

         // cut walk: memory read issued here
         S_CUT_CHECK: begin
            if (idx_ff >= siu_ff) begin
               state_in = S_FINISH;
            end else if (!nz_ff[idx_ff[IW-1:0]]) begin
               idx_in = idx_ff + SW'(1);
            end else begin
               state_in = S_CUT_EVAL;
            end
         end

         // overlap test and leftover pieces
         S_CUT_EVAL: begin
            if (s < e) begin
               nz_in[idx_ff[IW-1:0]] = 1'b0;
               if (s > lo) begin
                  add_addr_in = 64'(lo);
                  add_len_in  = 64'(s - lo);
                  pend2_in    = (e < hi);
                  p2_addr_in  = e;
                  p2_len_in   = hi - e;
                  state_in    = S_ADD_PREP1;
               end else if (e < hi) begin
                  add_addr_in = 64'(e);
                  add_len_in  = 64'(hi - e);
                  pend2_in    = 1'b0;
                  state_in    = S_ADD_PREP1;
               end else begin
                  idx_in   = idx_ff + SW'(1);
                  state_in = S_CUT_CHECK;
               end
            end else begin
               idx_in   = idx_ff + SW'(1);
               state_in = S_CUT_CHECK;
            end
         end

         // alloc walk: memory read issued here
         S_ALLOC_CHECK: begin
            if (idx_ff >= siu_ff) begin
               st_in    = ST_NO_MEM;
               state_in = S_FINISH;
            end else if (!nz_ff[idx_ff[IW-1:0]]) begin
               idx_in = idx_ff + SW'(1);
            end else begin
               state_in = S_ALLOC_EVAL;
            end
         end

         // take the front page
         S_ALLOC_EVAL: begin
            wr_en                 = 1'b1;
            wr_addr               = idx_ff[IW-1:0];
            wr_data               = '{base: rd_data.base + PAGE_BYTES, size: newsize};
            nz_in[idx_ff[IW-1:0]] = (newsize != 32'd0);
            page_in               = rd_data.base;
            total_in              = total_ff + PAGE_BYTES;
            state_in              = S_FINISH;
         end

         // load the result word once the register is free
         S_FINISH: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = st_ff;
               rsp_page_in   = page_ff;
               rsp_ext_in    = 6'(siu_ff);
               rsp_hm_in     = hw_ff;
               rsp_tot_in    = total_ff;
               state_in      = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

endmodule
